FILE: src/cartridge_bank_mapper_top_macros.svh
// assertion macros for the cartridge bank mapper
// used by cartridge_bank_mapper_top, no other dependencies
`ifndef CARTRIDGE_BANK_MAPPER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_MACROS_SVH

`ifndef SYNTH
`define CBM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cbm check failed");
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbm check failed");
`else
`define CBM_ASSERT(label, clk, rst_n, prop)
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cbm_pkg.sv
// types and constants shared by the cartridge bank mapper
// no dependencies
`default_nettype none

package cbm_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 9;
	localparam int MAP_ADDR_W = 22;

	typedef enum logic [2:0] {
		FN_PRG_RD = 3'd0,
		FN_PRG_WR = 3'd1,
		FN_CHR_RD = 3'd2,
		FN_CHR_WR = 3'd3,
		FN_NT     = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_RAM = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_CHR_ROM = 3'd3,
		TGT_CHR_RAM = 3'd4,
		TGT_NT_RAM  = 3'd5
	} tgt_t;

	typedef enum logic [1:0] {
		KIND_FIXED  = 2'd0,
		KIND_SERIAL = 2'd1,
		KIND_SWITCH = 2'd2,
		KIND_ALIAS  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MIR_SINGLE_LO = 2'd0,
		MIR_SINGLE_HI = 2'd1,
		MIR_VERT      = 2'd2,
		MIR_HORIZ     = 2'd3
	} mir_t;

	typedef enum logic [1:0] {
		PMODE_PAIR_A    = 2'd0,
		PMODE_PAIR_B    = 2'd1,
		PMODE_FIX_FIRST = 2'd2,
		PMODE_FIX_LAST  = 2'd3
	} pmode_t;

	typedef enum logic [1:0] {
		SEL_CTRL     = 2'd0,
		SEL_CHR_LOW  = 2'd1,
		SEL_CHR_HIGH = 2'd2,
		SEL_PRG      = 2'd3
	} sel_t;

	localparam logic [CFG_IDX_W-1:0] CFG_KIND       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_MIR    = 4'd3;

	localparam logic [15:0] PRG_RAM_BASE = 16'h6000;
	localparam logic [15:0] PRG_ROM_BASE = 16'h8000;
	localparam logic [15:0] CHR_END      = 16'h2000;
	localparam logic [15:0] CHR_HALF     = 16'h1000;
	localparam logic [2:0]  SHIFT_LAST   = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [8:0] bank_count;
		logic       chr_is_ram;
		logic       header_mirroring;
	} cfg_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [4:0] shift_value;
		logic [2:0] shift_writes;
		logic [1:0] mirroring_mode;
		logic [1:0] prg_mode;
		logic       chr_mode;
		logic [4:0] chr_bank_low;
		logic [4:0] chr_bank_high;
		logic       high_is_last;
	} map_st_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] address;
		logic [7:0]  write_data;
	} access_t;

	typedef struct packed {
		tgt_t                  target;
		logic                  write_enable;
		logic [MAP_ADDR_W-1:0] mapped_address;
	} answer_t;

endpackage

`default_nettype wire

FILE: src/cbm_if.sv
// valid/ready channel interfaces of the cartridge bank mapper
// depends on cbm_pkg
`default_nettype none

interface cbm_access_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, output func, output address, output write_data,
		input ready);
	modport sink (input valid, input func, input address, input write_data,
		output ready);
endinterface

interface cbm_answer_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     target;
	logic                           write_enable;
	logic [cbm_pkg::MAP_ADDR_W-1:0] mapped_address;

	modport source (output valid, output target, output write_enable,
		output mapped_address, input ready);
	modport sink (input valid, input target, input write_enable,
		input mapped_address, output ready);
endinterface

interface cbm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cbm_pkg::CFG_IDX_W-1:0]  index;
	logic [cbm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/cbm_regs.sv
// configuration registers and bank/shift state of the mapper
// depends on cbm_pkg
`default_nettype none

module cbm_regs #(
	parameter int PRG_BANK_BITS = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  cbm_pkg::cfg_wr_t        cfg_wr,
	input  wire                     load,
	input  cbm_pkg::map_st_t        st_d,
	input  wire [PRG_BANK_BITS-1:0] prg_low_d,
	input  wire [PRG_BANK_BITS-1:0] prg_high_d,
	output cbm_pkg::cfg_t           cfg,
	output cbm_pkg::map_st_t        st,
	output logic [PRG_BANK_BITS-1:0] prg_low,
	output logic [PRG_BANK_BITS-1:0] prg_high
);
	import cbm_pkg::*;

	cfg_t                     cfg_q;
	map_st_t                  st_q;
	logic [PRG_BANK_BITS-1:0] prg_low_q;
	logic [PRG_BANK_BITS-1:0] prg_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind             <= KIND_FIXED;
			cfg_q.bank_count       <= 9'd2;
			cfg_q.chr_is_ram       <= 1'b1;
			cfg_q.header_mirroring <= 1'b0;
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.index)
				CFG_KIND:       cfg_q.kind <= cfg_wr.data[1:0];
				CFG_BANK_COUNT: cfg_q.bank_count <= cfg_wr.data[8:0];
				CFG_CHR_RAM:    cfg_q.chr_is_ram <= cfg_wr.data[0];
				CFG_HDR_MIR:    cfg_q.header_mirroring <= cfg_wr.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.shift_value    <= '0;
			st_q.shift_writes   <= '0;
			st_q.mirroring_mode <= MIR_SINGLE_LO;
			st_q.prg_mode       <= PMODE_FIX_LAST;
			st_q.chr_mode       <= 1'b0;
			st_q.chr_bank_low   <= '0;
			st_q.chr_bank_high  <= '0;
			st_q.high_is_last   <= 1'b1;
			prg_low_q  <= '0;
			prg_high_q <= '0;
		end else if (load) begin
			st_q       <= st_d;
			prg_low_q  <= prg_low_d;
			prg_high_q <= prg_high_d;
		end
	end

	assign cfg      = cfg_q;
	assign st       = st_q;
	assign prg_low  = prg_low_q;
	assign prg_high = prg_high_q;

endmodule

`default_nettype wire

FILE: src/cbm_decode.sv
// access decode: target, write enable, mapped address and next mapper state
// depends on cbm_pkg
`default_nettype none

module cbm_decode #(
	parameter int PRG_BANK_BITS = 8
) (
	input  cbm_pkg::access_t          acc,
	input  cbm_pkg::cfg_t             cfg,
	input  cbm_pkg::map_st_t          st,
	input  wire [PRG_BANK_BITS-1:0]   prg_low,
	input  wire [PRG_BANK_BITS-1:0]   prg_high,
	output cbm_pkg::answer_t          ans,
	output cbm_pkg::map_st_t          st_d,
	output logic [PRG_BANK_BITS-1:0]  prg_low_d,
	output logic [PRG_BANK_BITS-1:0]  prg_high_d
);
	import cbm_pkg::*;

	logic [PRG_BANK_BITS-1:0]  last_bank;
	logic [PRG_BANK_BITS-1:0]  bank;
	logic [PRG_BANK_BITS+13:0] prg_off;
	logic [17:0]               chr_off;
	logic [10:0]               nt_off;
	logic [1:0]                nt_mode;
	logic                      is_high;
	logic [2:0]                sw_inc;
	logic [4:0]                sv_new;

	assign last_bank = (cfg.bank_count == 9'd0) ? '0 : PRG_BANK_BITS'(cfg.bank_count - 9'd1);
	assign is_high   = acc.address[14];
	assign sw_inc    = 3'(st.shift_writes + 3'd1);
	assign sv_new    = {acc.write_data[0], st.shift_value[4:1]};

	// program bank seen at this address
	always_comb begin
		case (cfg.kind)
			KIND_SERIAL: bank = !is_high ? prg_low : (st.high_is_last ? last_bank : prg_high);
			KIND_SWITCH: bank = is_high ? last_bank : prg_low;
			default:     bank = (is_high && cfg.bank_count >= 9'd2) ? PRG_BANK_BITS'(1) : '0;
		endcase
	end

	assign prg_off = {bank, acc.address[13:0]};

	always_comb begin
		if (cfg.kind != KIND_SERIAL) begin
			chr_off = 18'(acc.address[12:0]);
		end else if (!st.chr_mode || acc.address < CHR_HALF) begin
			chr_off = 18'({st.chr_bank_low, 12'h000}) + 18'(acc.address[12:0]);
		end else begin
			chr_off = 18'({st.chr_bank_high, acc.address[11:0]});
		end
	end

	assign nt_mode = (cfg.kind == KIND_SERIAL) ? st.mirroring_mode
		: (cfg.header_mirroring ? MIR_VERT : MIR_HORIZ);

	always_comb begin
		unique case (nt_mode)
			MIR_SINGLE_LO: nt_off = {1'b0, acc.address[9:0]};
			MIR_SINGLE_HI: nt_off = {1'b1, acc.address[9:0]};
			MIR_VERT:      nt_off = acc.address[10:0];
			default:       nt_off = {acc.address[11], acc.address[9:0]};
		endcase
	end

	always_comb begin
		ans.target         = TGT_NONE;
		ans.write_enable   = 1'b0;
		ans.mapped_address = '0;
		st_d       = st;
		prg_low_d  = prg_low;
		prg_high_d = prg_high;

		unique case (acc.func) inside
			FN_PRG_RD, FN_PRG_WR: begin
				if (acc.address < PRG_RAM_BASE) begin
				end else if (acc.address < PRG_ROM_BASE) begin
					ans.target         = TGT_PRG_RAM;
					ans.write_enable   = (acc.func == FN_PRG_WR);
					ans.mapped_address = MAP_ADDR_W'(acc.address[12:0]);
				end else if (acc.func == FN_PRG_RD) begin
					ans.target         = TGT_PRG_ROM;
					ans.mapped_address = MAP_ADDR_W'(prg_off);
				end else if (cfg.kind == KIND_SWITCH) begin
					prg_low_d = PRG_BANK_BITS'(acc.write_data);
				end else if (cfg.kind == KIND_SERIAL) begin
					if (acc.write_data[7]) begin
						// serial reset beat
						st_d.shift_value  = '0;
						st_d.shift_writes = '0;
						st_d.prg_mode     = PMODE_FIX_LAST;
						st_d.high_is_last = 1'b1;
					end else if (sw_inc != SHIFT_LAST) begin
						st_d.shift_value  = sv_new;
						st_d.shift_writes = sw_inc;
					end else begin
						st_d.shift_value  = '0;
						st_d.shift_writes = '0;
						unique case (acc.address[14:13])
							SEL_CTRL: begin
								st_d.mirroring_mode = sv_new[1:0];
								st_d.prg_mode       = sv_new[3:2];
								st_d.chr_mode       = sv_new[4];
							end
							SEL_CHR_LOW: st_d.chr_bank_low = st.chr_mode ? sv_new
								: {sv_new[4:1], 1'b0};
							SEL_CHR_HIGH: st_d.chr_bank_high = sv_new;
							default: begin
								unique case (st.prg_mode)
									PMODE_FIX_FIRST: begin
										prg_low_d         = '0;
										prg_high_d        = PRG_BANK_BITS'(sv_new[3:0]);
										st_d.high_is_last = 1'b0;
									end
									PMODE_FIX_LAST: begin
										prg_low_d         = PRG_BANK_BITS'(sv_new[3:0]);
										st_d.high_is_last = 1'b1;
									end
									default: begin
										prg_low_d         = PRG_BANK_BITS'({sv_new[3:1], 1'b0});
										prg_high_d        = PRG_BANK_BITS'({sv_new[3:1], 1'b1});
										st_d.high_is_last = 1'b0;
									end
								endcase
							end
						endcase
					end
				end
			end
			FN_CHR_RD, FN_CHR_WR: begin
				if (acc.address < CHR_END && !(acc.func == FN_CHR_WR && !cfg.chr_is_ram)) begin
					ans.target         = cfg.chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
					ans.write_enable   = (acc.func == FN_CHR_WR);
					ans.mapped_address = MAP_ADDR_W'(chr_off);
				end
			end
			FN_NT: begin
				ans.target         = TGT_NT_RAM;
				ans.mapped_address = MAP_ADDR_W'(nt_off);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/cartridge_bank_mapper_top.sv
// accesses pass the input beat register, then decode into the answer register
// one access per cycle if answers flow; state written by one is seen by the next
// the answer register decouples the sides, so a new access enters while one waits
// reset (arst_n low): fixed-bank kind, two program banks, char RAM, horizontal
// mirroring; serial state cleared with the last program bank fixed high
`default_nettype none
`include "cartridge_bank_mapper_top_macros.svh"

module cartridge_bank_mapper_top #(
	parameter int PRG_BANK_BITS = 8
) (
	input wire            clk,
	input wire            arst_n,
	cbm_access_if.sink    access,
	cbm_answer_if.source  answer,
	cbm_cfg_if.sink       cfg
);
	import cbm_pkg::*;

	logic                     valid_s1;
	access_t                  acc_s1;
	logic                     out_valid_q;
	answer_t                  ans_q;
	logic                     adv;
	logic                     fire;
	answer_t                  ans_d;
	cfg_t                     cfg_cur;
	cfg_wr_t                  cfg_wr;
	map_st_t                  st;
	map_st_t                  st_d;
	logic [PRG_BANK_BITS-1:0] prg_low;
	logic [PRG_BANK_BITS-1:0] prg_high;
	logic [PRG_BANK_BITS-1:0] prg_low_d;
	logic [PRG_BANK_BITS-1:0] prg_high_d;

	assign adv  = !out_valid_q || answer.ready;
	assign fire = valid_s1 && adv;
	assign access.ready = !valid_s1 || adv;
	assign cfg.ready    = 1'b1;

	assign cfg_wr.en    = cfg.valid && cfg.ready;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (access.ready) begin
			valid_s1 <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access.valid && access.ready) begin
			acc_s1.func       <= access.func;
			acc_s1.address    <= access.address;
			acc_s1.write_data <= access.write_data;
		end
	end

	cbm_regs #(.PRG_BANK_BITS(PRG_BANK_BITS)) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.load       (fire),
		.st_d       (st_d),
		.prg_low_d  (prg_low_d),
		.prg_high_d (prg_high_d),
		.cfg        (cfg_cur),
		.st         (st),
		.prg_low    (prg_low),
		.prg_high   (prg_high)
	);

	cbm_decode #(.PRG_BANK_BITS(PRG_BANK_BITS)) u_decode (
		.acc        (acc_s1),
		.cfg        (cfg_cur),
		.st         (st),
		.prg_low    (prg_low),
		.prg_high   (prg_high),
		.ans        (ans_d),
		.st_d       (st_d),
		.prg_low_d  (prg_low_d),
		.prg_high_d (prg_high_d)
	);

	// answer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ans_q <= ans_d;
		end
	end

	assign answer.valid          = out_valid_q;
	assign answer.target         = ans_q.target;
	assign answer.write_enable   = ans_q.write_enable;
	assign answer.mapped_address = ans_q.mapped_address;

	`CBM_ASSERT(a_shift_bound, clk, arst_n, st.shift_writes < SHIFT_LAST)
	`CBM_ASSERT(a_stall_blocks, clk, arst_n, (valid_s1 && out_valid_q && !answer.ready) |-> !access.ready)
	`CBM_ASSERT_NEXT(a_beat_lands, clk, arst_n, access.valid && access.ready, valid_s1)
	`CBM_ASSERT(a_none_is_zero, clk, arst_n, (out_valid_q && ans_q.target == TGT_NONE) |-> (ans_q.mapped_address == '0 && !ans_q.write_enable))
	`CBM_ASSERT(a_nt_range, clk, arst_n, (out_valid_q && ans_q.target == TGT_NT_RAM) |-> (!ans_q.write_enable && ans_q.mapped_address < MAP_ADDR_W'(12'h800)))

endmodule

`default_nettype wire

FILE: sim/cbm_answer_check.sv
// answer checker for the cartridge bank mapper: watches the access, answer and config
// channels, predicts each answer from its own copy of the mapper state and compares
// depends on cbm_pkg and the channel interfaces in cbm_if
module cbm_answer_check (
	input wire clk,
	input wire arst_n,
	cbm_access_if access,
	cbm_answer_if answer,
	cbm_cfg_if cfg,
	output int unsigned mismatch_count,
	output int unsigned pending_answers
);
	import cbm_pkg::*;

	cfg_t       mode_regs;
	logic [4:0] shift_value;
	logic [2:0] shift_writes;
	mir_t       mirroring;
	pmode_t     prg_mode;
	logic       chr_mode;
	logic [4:0] chr_bank_lo;
	logic [4:0] chr_bank_hi;
	logic [7:0] prg_bank_lo;
	logic [7:0] prg_bank_hi;
	logic       high_is_last;
	answer_t    answers_due[$];

	function automatic logic [7:0] last_bank();
		if (mode_regs.bank_count == 9'd0)
			return 8'd0;
		return 8'(mode_regs.bank_count - 9'd1);
	endfunction

	function automatic logic [7:0] rom_bank(input logic upper);
		case (mode_regs.kind)
			KIND_SERIAL: begin
				if (!upper)
					return prg_bank_lo;
				return high_is_last ? last_bank() : prg_bank_hi;
			end
			KIND_SWITCH: return upper ? last_bank() : prg_bank_lo;
			default: return (upper && mode_regs.bank_count >= 9'd2) ? 8'd1 : 8'd0;
		endcase
	endfunction

	function automatic void shift_in_bit(input logic [15:0] addr, input logic [7:0] data);
		logic [4:0] v;
		if (data[7]) begin
			shift_value = '0;
			shift_writes = '0;
			prg_mode = PMODE_FIX_LAST;
			high_is_last = 1'b1;
			return;
		end
		shift_writes = shift_writes + 3'd1;
		shift_value = {data[0], shift_value[4:1]};
		if (shift_writes != SHIFT_LAST)
			return;
		v = shift_value;
		case (addr[14:13])
			SEL_CTRL: begin
				mirroring = mir_t'(v[1:0]);
				prg_mode = pmode_t'(v[3:2]);
				chr_mode = v[4];
			end
			SEL_CHR_LOW: chr_bank_lo = chr_mode ? v : {v[4:1], 1'b0};
			SEL_CHR_HIGH: chr_bank_hi = v;
			SEL_PRG: begin
				if (prg_mode == PMODE_PAIR_A || prg_mode == PMODE_PAIR_B) begin
					prg_bank_lo = {4'd0, v[3:1], 1'b0};
					prg_bank_hi = {4'd0, v[3:1], 1'b1};
					high_is_last = 1'b0;
				end else if (prg_mode == PMODE_FIX_FIRST) begin
					prg_bank_lo = 8'd0;
					prg_bank_hi = {4'd0, v[3:0]};
					high_is_last = 1'b0;
				end else begin
					prg_bank_lo = {4'd0, v[3:0]};
					high_is_last = 1'b1;
				end
			end
		endcase
		shift_value = '0;
		shift_writes = '0;
	endfunction

	function automatic answer_t map_access(input logic [2:0] fn, input logic [15:0] addr,
		input logic [7:0] data);
		answer_t r;
		mir_t fold;
		r.target = TGT_NONE;
		r.write_enable = 1'b0;
		r.mapped_address = '0;
		case (fn)
			FN_PRG_RD, FN_PRG_WR: begin
				if (addr >= PRG_RAM_BASE && addr < PRG_ROM_BASE) begin
					r.target = TGT_PRG_RAM;
					r.write_enable = (fn == FN_PRG_WR);
					r.mapped_address = MAP_ADDR_W'(addr[12:0]);
				end else if (addr >= PRG_ROM_BASE && fn == FN_PRG_RD) begin
					r.target = TGT_PRG_ROM;
					r.mapped_address = {rom_bank(addr[14]), addr[13:0]};
				end else if (addr >= PRG_ROM_BASE) begin
					if (mode_regs.kind == KIND_SERIAL)
						shift_in_bit(addr, data);
					else if (mode_regs.kind == KIND_SWITCH)
						prg_bank_lo = data;
				end
			end
			FN_CHR_RD, FN_CHR_WR: begin
				if (addr < CHR_END && (fn == FN_CHR_RD || mode_regs.chr_is_ram)) begin
					if (mode_regs.chr_is_ram)
						r.target = TGT_CHR_RAM;
					else
						r.target = TGT_CHR_ROM;
					r.write_enable = (fn == FN_CHR_WR);
					if (mode_regs.kind != KIND_SERIAL)
						r.mapped_address = MAP_ADDR_W'(addr);
					else if (!chr_mode || addr < CHR_HALF)
						r.mapped_address = {5'd0, chr_bank_lo, 12'd0} + MAP_ADDR_W'(addr);
					else
						r.mapped_address = {5'd0, chr_bank_hi, 12'd0}
							+ MAP_ADDR_W'(addr - CHR_HALF);
				end
			end
			FN_NT: begin
				if (mode_regs.kind == KIND_SERIAL)
					fold = mirroring;
				else if (mode_regs.header_mirroring)
					fold = MIR_VERT;
				else
					fold = MIR_HORIZ;
				r.target = TGT_NT_RAM;
				case (fold)
					MIR_SINGLE_LO: r.mapped_address = {12'd0, addr[9:0]};
					MIR_SINGLE_HI: r.mapped_address = {11'd0, 1'b1, addr[9:0]};
					MIR_VERT: r.mapped_address = {11'd0, addr[10:0]};
					default: r.mapped_address = {11'd0, addr[11], addr[9:0]};
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		if (!arst_n) begin
			mode_regs.kind = KIND_FIXED;
			mode_regs.bank_count = 9'd2;
			mode_regs.chr_is_ram = 1'b1;
			mode_regs.header_mirroring = 1'b0;
			shift_value = '0;
			shift_writes = '0;
			mirroring = MIR_SINGLE_LO;
			prg_mode = PMODE_FIX_LAST;
			chr_mode = 1'b0;
			chr_bank_lo = '0;
			chr_bank_hi = '0;
			prg_bank_lo = '0;
			prg_bank_hi = '0;
			high_is_last = 1'b1;
			answers_due.delete();
			mismatch_count = 0;
			pending_answers = 0;
		end else begin
			if (answer.valid && answer.ready) begin
				got.target = tgt_t'(answer.target);
				got.write_enable = answer.write_enable;
				got.mapped_address = answer.mapped_address;
				if (answers_due.size() == 0) begin
					$display("%0t: answer target %0d we %0d addr %h with none expected",
						$time, got.target, got.write_enable, got.mapped_address);
					mismatch_count++;
				end else begin
					want = answers_due.pop_front();
					if (got.target !== want.target) begin
						$display("%0t: target expected %0d got %0d",
							$time, want.target, got.target);
						mismatch_count++;
					end
					if (got.write_enable !== want.write_enable) begin
						$display("%0t: write_enable expected %0d got %0d",
							$time, want.write_enable, got.write_enable);
						mismatch_count++;
					end
					if (got.mapped_address !== want.mapped_address) begin
						$display("%0t: mapped_address expected %h got %h",
							$time, want.mapped_address, got.mapped_address);
						mismatch_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_KIND: mode_regs.kind = cfg.data[1:0];
					CFG_BANK_COUNT: mode_regs.bank_count = cfg.data[8:0];
					CFG_CHR_RAM: mode_regs.chr_is_ram = cfg.data[0];
					CFG_HDR_MIR: mode_regs.header_mirroring = cfg.data[0];
					default: ;
				endcase
			end
			if (access.valid && access.ready)
				answers_due.push_back(map_access(access.func, access.address,
					access.write_data));
			pending_answers = answers_due.size();
		end
	end

endmodule

FILE: sim/cartridge_bank_mapper_top_tb.sv
// testbench top for cartridge_bank_mapper_top: drives config writes, and accesses
// with random gaps while answers stall at random, cbm_answer_check predicts and compares the answers
// depends on cbm_pkg, cbm_if, cbm_answer_check and the mapper RTL
module cartridge_bank_mapper_top_tb;
	import cbm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	int unsigned mismatch_count;
	int unsigned pending_answers;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_left;

	cbm_access_if acc_bus ();
	cbm_answer_if ans_bus ();
	cbm_cfg_if    cfg_bus ();

	cartridge_bank_mapper_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.access(acc_bus),
		.answer(ans_bus),
		.cfg(cfg_bus)
	);

	cbm_answer_check answer_check (
		.clk(clk),
		.arst_n(arst_n),
		.access(acc_bus),
		.answer(ans_bus),
		.cfg(cfg_bus),
		.mismatch_count(mismatch_count),
		.pending_answers(pending_answers)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timed out with %0d answers pending", $time, pending_answers);
		$display("Mismatches found");
		$finish;
	end

	// answer side: random stalls plus a long hold-off on request
	initial begin
		ans_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				ans_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				ans_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic put_access(input logic [2:0] fn, input logic [15:0] addr,
		input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			acc_bus.valid <= 1'b0;
			@(negedge clk);
		end
		acc_bus.valid <= 1'b1;
		acc_bus.func <= fn;
		acc_bus.address <= addr;
		acc_bus.write_data <= data;
		@(posedge clk);
		while (!acc_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_mode(input kind_t kind, input logic [8:0] count, input logic ram,
		input logic mir);
		write_reg(CFG_KIND, CFG_DATA_W'(kind));
		write_reg(CFG_BANK_COUNT, count);
		write_reg(CFG_CHR_RAM, CFG_DATA_W'(ram));
		write_reg(CFG_HDR_MIR, CFG_DATA_W'(mir));
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		acc_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_answers != 0);
		repeat (4) @(negedge clk);
	endtask

	// five one-bit writes that load one serial register
	task automatic load_serial(input sel_t sel, input logic [4:0] value);
		logic [15:0] addr;
		for (int i = 0; i < 5; i++) begin
			addr = {1'b1, sel, 13'($urandom)};
			put_access(FN_PRG_WR, addr, {1'b0, 6'($urandom), value[i]});
		end
	endtask

	task automatic random_access();
		logic [2:0]  fn;
		logic [15:0] addr;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 22)
			fn = FN_PRG_RD;
		else if (pick < 42)
			fn = FN_PRG_WR;
		else if (pick < 62)
			fn = FN_CHR_RD;
		else if (pick < 77)
			fn = FN_CHR_WR;
		else if (pick < 95)
			fn = FN_NT;
		else
			fn = 3'($urandom_range(5, 7));
		addr = 16'($urandom);
		if ((fn == FN_CHR_RD || fn == FN_CHR_WR) && $urandom_range(3) != 0)
			addr[15:13] = 3'd0;
		if ((fn == FN_PRG_RD || fn == FN_PRG_WR) && $urandom_range(3) != 0)
			addr[15] = 1'b1;
		put_access(fn, addr, 8'($urandom));
	endtask

	task automatic run_phase(input kind_t kind, input logic [8:0] count, input logic ram,
		input logic mir, input int unsigned idle, input int unsigned stall,
		input int unsigned items);
		int unsigned sent;
		logic        held;
		logic        paused;
		set_mode(kind, count, ram, mir);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		sent = 0;
		held = 1'b0;
		paused = 1'b0;
		while (sent < items) begin
			if (!held && sent >= items / 3) begin
				hold_left = 60;
				held = 1'b1;
			end
			if (!paused && sent >= items / 2) begin
				wait_quiet();
				paused = 1'b1;
			end
			if (kind == KIND_SERIAL && $urandom_range(99) < 45) begin
				if ($urandom_range(9) == 0) begin
					put_access(FN_PRG_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
					sent += 1;
				end else begin
					load_serial(sel_t'($urandom_range(3)), 5'($urandom));
					sent += 5;
				end
			end else begin
				random_access();
				sent += 1;
			end
		end
		wait_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		acc_bus.valid = 1'b0;
		acc_bus.func = FN_PRG_RD;
		acc_bus.address = '0;
		acc_bus.write_data = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_KIND;
		cfg_bus.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		set_mode(KIND_SERIAL, 9'd16, 1'b0, 1'b1);
		put_access(FN_PRG_RD, 16'h0000, 8'h00);
		put_access(FN_PRG_WR, 16'h5FFF, 8'hFF);
		put_access(FN_PRG_WR, 16'h6000, 8'hFF);
		put_access(FN_PRG_RD, 16'h7FFF, 8'h00);
		// bit 7 clears the shift register
		put_access(FN_PRG_WR, 16'hFFFF, 8'h80);
		load_serial(SEL_CTRL, 5'b11101);
		load_serial(SEL_PRG, 5'b01111);
		put_access(FN_PRG_RD, 16'h8000, 8'h00);
		put_access(FN_PRG_RD, 16'hFFFF, 8'h00);
		put_access(FN_CHR_RD, 16'h1FFF, 8'h00);
		put_access(FN_CHR_WR, 16'h0000, 8'hFF);
		put_access(FN_CHR_RD, 16'h2000, 8'h00);
		put_access(FN_NT, 16'hFFFF, 8'h00);
		put_access(3'd7, 16'hFFFF, 8'hFF);
		wait_quiet();

		run_phase(KIND_SERIAL, 9'd16, 1'b1, 1'b0, 0, 0, 350);
		run_phase(KIND_SERIAL, 9'd256, 1'b0, 1'b1, 47, 0, 300);
		run_phase(KIND_SWITCH, 9'd1, 1'b1, 1'b0, 0, 47, 250);
		run_phase(KIND_FIXED, 9'd2, 1'b0, 1'b1, 29, 29, 200);
		run_phase(KIND_ALIAS, 9'd0, 1'b1, 1'b0, 0, 0, 120);
		run_phase(KIND_SWITCH, 9'd511, 1'b0, 1'b1, 47, 0, 150);
		run_phase(KIND_FIXED, 9'd1, 1'b1, 1'b1, 0, 47, 150);
		run_phase(KIND_SERIAL, 9'd8, 1'b1, 1'b1, 29, 29, 250);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
